// ----- hw/rtl/avkf_pkg.sv -----
package avkf_pkg;

    localparam int unsigned FX_W = 64;

    localparam logic [FX_W-1:0] FX_ONE  = 64'h0000_0001_0000_0000;
    localparam logic [FX_W-1:0] FX_HALF = 64'h0000_0000_8000_0000;
    localparam logic [FX_W-1:0] FX_TWO  = 64'h0000_0002_0000_0000;

    typedef logic [FX_W-1:0] fx_t;

    typedef enum logic [1:0] {
        CMD_INIT    = 2'd0,
        CMD_PREDICT = 2'd1,
        CMD_BARO    = 2'd2,
        CMD_GENERIC = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        REG_ACCEL_SIGMA = 3'd0,
        REG_BARO_SIGMA  = 3'd1,
        REG_INIT_ALT    = 3'd2,
        REG_INIT_VEL    = 3'd3,
        REG_INIT_VAR_A  = 3'd4,
        REG_INIT_VAR_V  = 3'd5
    } reg_idx_t;

    // Magnitude of a two's complement value
    function automatic fx_t fx_mag(input fx_t x);
        fx_mag = x[FX_W-1] ? (fx_t'(0) - x) : x;
    endfunction

    // Signed divide by four, truncated toward zero
    function automatic fx_t fx_div4(input fx_t x);
        fx_t m;
        m = fx_mag(x) >> 2;
        fx_div4 = x[FX_W-1] ? (fx_t'(0) - m) : m;
    endfunction

    // Signed divide by two, truncated toward zero
    function automatic fx_t fx_div2(input fx_t x);
        fx_t m;
        m = fx_mag(x) >> 1;
        fx_div2 = x[FX_W-1] ? (fx_t'(0) - m) : m;
    endfunction

endpackage

// ----- hw/rtl/avkf_mul.sv -----
module avkf_mul (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  avkf_pkg::fx_t a,
    input  avkf_pkg::fx_t b,
    output logic          done,
    output avkf_pkg::fx_t result
);
    import avkf_pkg::*;

    logic [31:0]  ua_lo_reg, ua_hi_reg, ub_lo_reg, ub_hi_reg;
    logic         neg_reg;
    logic         busy_reg;
    logic [2:0]   cnt_reg;
    logic [127:0] acc_reg;
    logic [127:0] acc_next;
    logic [127:0] acc_fin;
    logic [63:0]  pp;
    fx_t          ua, ub;
    logic         done_reg;
    fx_t          res_reg;

    assign ua = fx_mag(a);
    assign ub = fx_mag(b);

    // Pick one 32x32 partial product per cycle and add it at its weight
    always_comb
    begin
        pp       = 64'd0;
        acc_next = acc_reg;
        case (cnt_reg)
            3'd0:
            begin
                pp       = 64'(ua_lo_reg) * 64'(ub_lo_reg);
                acc_next = acc_reg + {64'd0, pp};
            end
            3'd1:
            begin
                pp       = 64'(ua_hi_reg) * 64'(ub_lo_reg);
                acc_next = acc_reg + {32'd0, pp, 32'd0};
            end
            3'd2:
            begin
                pp       = 64'(ua_lo_reg) * 64'(ub_hi_reg);
                acc_next = acc_reg + {32'd0, pp, 32'd0};
            end
            3'd3:
            begin
                pp       = 64'(ua_hi_reg) * 64'(ub_hi_reg);
                acc_next = acc_reg + {pp, 64'd0};
            end
            default:
            begin
                pp       = 64'd0;
                acc_next = acc_reg;
            end
        endcase
        acc_fin = neg_reg ? (128'd0 - acc_reg) : acc_reg;
    end

    // Sequence the partial products, then apply the sign and drop the fraction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            cnt_reg   <= 3'd0;
            acc_reg   <= 128'd0;
            neg_reg   <= 1'b0;
            ua_lo_reg <= 32'd0;
            ua_hi_reg <= 32'd0;
            ub_lo_reg <= 32'd0;
            ub_hi_reg <= 32'd0;
            res_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                cnt_reg   <= 3'd0;
                acc_reg   <= 128'd0;
                neg_reg   <= a[FX_W-1] ^ b[FX_W-1];
                ua_lo_reg <= ua[31:0];
                ua_hi_reg <= ua[63:32];
                ub_lo_reg <= ub[31:0];
                ub_hi_reg <= ub[63:32];
            end
            else if (busy_reg)
            begin
                if (cnt_reg == 3'd4)
                begin
                    res_reg  <= acc_fin[95:32];
                    done_reg <= 1'b1;
                    busy_reg <= 1'b0;
                end
                else
                begin
                    acc_reg <= acc_next;
                    cnt_reg <= cnt_reg + 3'd1;
                end
            end
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

// ----- hw/rtl/avkf_div.sv -----
module avkf_div (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  avkf_pkg::fx_t num,
    input  avkf_pkg::fx_t den,
    output logic          done,
    output avkf_pkg::fx_t result
);
    import avkf_pkg::*;

    logic [127:0] dvd_reg;
    fx_t          rem_reg, quo_reg, den_reg, res_reg;
    logic         neg_reg, busy_reg, fin_reg, done_reg;
    logic [6:0]   cnt_reg;
    fx_t          rem_sh;
    logic         ge;

    // One restoring step: shift in the next dividend bit and try a subtract
    assign rem_sh = {rem_reg[62:0], dvd_reg[127]};
    assign ge     = (rem_sh >= den_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dvd_reg  <= 128'd0;
            rem_reg  <= '0;
            quo_reg  <= '0;
            den_reg  <= '0;
            res_reg  <= '0;
            neg_reg  <= 1'b0;
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 7'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                dvd_reg  <= {32'd0, fx_mag(num), 32'd0};
                rem_reg  <= '0;
                quo_reg  <= '0;
                den_reg  <= den;
                neg_reg  <= num[FX_W-1];
                busy_reg <= 1'b1;
                cnt_reg  <= 7'd127;
            end
            else if (busy_reg)
            begin
                dvd_reg <= {dvd_reg[126:0], 1'b0};
                rem_reg <= ge ? (rem_sh - den_reg) : rem_sh;
                quo_reg <= {quo_reg[62:0], ge};
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd0)
                begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end
            else if (fin_reg)
            begin
                // Apply the sign of the numerator
                res_reg  <= neg_reg ? (fx_t'(0) - quo_reg) : quo_reg;
                fin_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

// ----- hw/rtl/altitude_velocity_kalman_filter.sv -----
// Two-state altitude/velocity Kalman filter in signed Q31.32. Each request runs
// one command (init, predict, barometric update or generic update) and returns
// one result with the state after the step and a status bit that flags a
// skipped update when the innovation variance is not positive. All products and
// quotients run on one shared 64x64 fixed-point multiplier (four 32x32 partial
// products) and one radix-2 divider. Init uses neither, predict takes 15
// products, a generic update 25 products and 2 quotients, and a barometric
// update one product more; an update that is skipped stops once the
// innovation variance is formed. A new request is taken only once the
// previous result has been delivered.
module altitude_velocity_kalman_filter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  cmd,
    input  logic [63:0] accel,
    input  logic [62:0] dt,
    input  logic [63:0] measurement,
    input  logic [63:0] predicted_measurement,
    input  logic [63:0] sens_alt,
    input  logic [63:0] sens_vel,
    input  logic [62:0] noise_var,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] altitude,
    output logic [63:0] velocity,
    output logic [63:0] cov_aa,
    output logic [63:0] cov_av,
    output logic [63:0] cov_va,
    output logic [63:0] cov_vv,
    output logic        status
);
    import avkf_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE,
        S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_P7, S_P8,
        S_P9, S_P10, S_P11, S_P12, S_P13, S_P14, S_P15,
        S_U0,
        S_U1, S_U2, S_U3, S_U4, S_U5, S_U6, S_U7, S_U8, S_U9,
        S_U10, S_U11, S_U12, S_U13, S_U14, S_U15, S_U16, S_U17, S_U18,
        S_U19, S_U20, S_U21, S_U22, S_U23, S_U24, S_U25, S_U26, S_U27,
        S_OUT
    } state_t;

    state_t      state_reg;
    logic        issued_reg;
    logic        status_reg;

    // Configuration
    logic [62:0] accel_sigma_reg, baro_sigma_reg, var_a_reg, var_v_reg;
    fx_t         init_alt_reg, init_vel_reg;

    // Filter state
    fx_t         alt_reg, vel_reg, paa_reg, pav_reg, pva_reg, pvv_reg;

    // Operands of the current request
    fx_t         dt_reg, accel_reg, z_reg, zp_reg, h0_reg, h1_reg, r_reg;

    // Scratch
    fx_t         ta_reg, tb_reg, tc_reg, td_reg, te_reg;
    fx_t         tf_reg, tg_reg, th_reg, ti_reg, tj_reg;

    fx_t         mul_a, mul_b, mul_res, div_res, s_val;
    logic        mul_start, mul_done, div_start, div_done, is_mul_step;
    logic        s_bad;

    avkf_mul u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .a      (mul_a),
        .b      (mul_b),
        .done   (mul_done),
        .result (mul_res)
    );

    avkf_div u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .num    ((state_reg == S_U12) ? tc_reg : td_reg),
        .den    (tb_reg),
        .done   (div_done),
        .result (div_res)
    );

    // Route the multiplier operands for each step
    always_comb
    begin
        mul_a       = '0;
        mul_b       = '0;
        is_mul_step = 1'b1;
        unique case (state_reg)
            S_P1:  begin mul_a = vel_reg;   mul_b = dt_reg;    end
            S_P2:  begin mul_a = FX_HALF;   mul_b = accel_reg; end
            S_P3:  begin mul_a = tb_reg;    mul_b = dt_reg;    end
            S_P4:  begin mul_a = tb_reg;    mul_b = dt_reg;    end
            S_P5:  begin mul_a = accel_reg; mul_b = dt_reg;    end
            S_P6:  begin mul_a = dt_reg;    mul_b = pva_reg;   end
            S_P7:  begin mul_a = dt_reg;    mul_b = pvv_reg;   end
            S_P8:  begin mul_a = dt_reg;    mul_b = dt_reg;    end
            S_P9:  begin mul_a = tg_reg;    mul_b = dt_reg;    end
            S_P10: begin mul_a = th_reg;    mul_b = dt_reg;    end
            S_P11:
            begin
                mul_a = {1'b0, accel_sigma_reg};
                mul_b = {1'b0, accel_sigma_reg};
            end
            S_P12: begin mul_a = tj_reg;    mul_b = ti_reg;    end
            S_P13: begin mul_a = tj_reg;    mul_b = th_reg;    end
            S_P14: begin mul_a = tj_reg;    mul_b = tg_reg;    end
            S_P15: begin mul_a = dt_reg;    mul_b = te_reg;    end
            S_U0:
            begin
                mul_a = {1'b0, baro_sigma_reg};
                mul_b = {1'b0, baro_sigma_reg};
            end
            S_U1:  begin mul_a = h0_reg;    mul_b = h0_reg;    end
            S_U2:  begin mul_a = ta_reg;    mul_b = paa_reg;   end
            S_U3:  begin mul_a = FX_TWO;    mul_b = h0_reg;    end
            S_U4:  begin mul_a = ta_reg;    mul_b = h1_reg;    end
            S_U5:  begin mul_a = ta_reg;    mul_b = pav_reg;   end
            S_U6:  begin mul_a = h1_reg;    mul_b = h1_reg;    end
            S_U7:  begin mul_a = ta_reg;    mul_b = pvv_reg;   end
            S_U8:  begin mul_a = h0_reg;    mul_b = paa_reg;   end
            S_U9:  begin mul_a = h1_reg;    mul_b = pav_reg;   end
            S_U10: begin mul_a = h0_reg;    mul_b = pva_reg;   end
            S_U11: begin mul_a = h1_reg;    mul_b = pvv_reg;   end
            S_U14: begin mul_a = tc_reg;    mul_b = te_reg;    end
            S_U15: begin mul_a = td_reg;    mul_b = te_reg;    end
            S_U16: begin mul_a = tc_reg;    mul_b = h0_reg;    end
            S_U17: begin mul_a = td_reg;    mul_b = h1_reg;    end
            S_U18: begin mul_a = tc_reg;    mul_b = h1_reg;    end
            S_U19: begin mul_a = th_reg;    mul_b = paa_reg;   end
            S_U20: begin mul_a = tj_reg;    mul_b = pva_reg;   end
            S_U21: begin mul_a = th_reg;    mul_b = pav_reg;   end
            S_U22: begin mul_a = tj_reg;    mul_b = pvv_reg;   end
            S_U23: begin mul_a = fx_t'(0) - td_reg; mul_b = h0_reg; end
            S_U24: begin mul_a = tj_reg;    mul_b = paa_reg;   end
            S_U25: begin mul_a = ti_reg;    mul_b = pva_reg;   end
            S_U26: begin mul_a = tj_reg;    mul_b = pav_reg;   end
            S_U27: begin mul_a = ti_reg;    mul_b = pvv_reg;   end
            default: is_mul_step = 1'b0;
        endcase
    end

    assign mul_start = is_mul_step && !issued_reg;
    assign div_start = ((state_reg == S_U12) || (state_reg == S_U13)) && !issued_reg;

    // Innovation variance and its sign check
    assign s_val = tb_reg + mul_res + r_reg;
    assign s_bad = s_val[FX_W-1] || (s_val == '0);

    // Sequencer, configuration and filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            issued_reg      <= 1'b0;
            status_reg      <= 1'b0;
            accel_sigma_reg <= '0;
            baro_sigma_reg  <= '0;
            var_a_reg       <= '0;
            var_v_reg       <= '0;
            init_alt_reg    <= '0;
            init_vel_reg    <= '0;
            alt_reg         <= '0;
            vel_reg         <= '0;
            paa_reg         <= '0;
            pav_reg         <= '0;
            pva_reg         <= '0;
            pvv_reg         <= '0;
            dt_reg          <= '0;
            accel_reg       <= '0;
            z_reg           <= '0;
            zp_reg          <= '0;
            h0_reg          <= '0;
            h1_reg          <= '0;
            r_reg           <= '0;
            ta_reg          <= '0;
            tb_reg          <= '0;
            tc_reg          <= '0;
            td_reg          <= '0;
            te_reg          <= '0;
            tf_reg          <= '0;
            tg_reg          <= '0;
            th_reg          <= '0;
            ti_reg          <= '0;
            tj_reg          <= '0;
        end
        else
        begin
            // Take configuration writes
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_ACCEL_SIGMA: accel_sigma_reg <= cfg_data[62:0];
                    REG_BARO_SIGMA:  baro_sigma_reg  <= cfg_data[62:0];
                    REG_INIT_ALT:    init_alt_reg    <= cfg_data;
                    REG_INIT_VEL:    init_vel_reg    <= cfg_data;
                    REG_INIT_VAR_A:  var_a_reg       <= cfg_data[62:0];
                    REG_INIT_VAR_V:  var_v_reg       <= cfg_data[62:0];
                    default: ;
                endcase
            end

            if (mul_start || div_start)
            begin
                issued_reg <= 1'b1;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        status_reg <= 1'b0;
                        dt_reg     <= {1'b0, dt};
                        accel_reg  <= accel;
                        z_reg      <= measurement;
                        unique case (cmd_t'(cmd))
                            CMD_INIT:
                            begin
                                alt_reg   <= init_alt_reg;
                                vel_reg   <= init_vel_reg;
                                paa_reg   <= {1'b0, var_a_reg};
                                pav_reg   <= '0;
                                pva_reg   <= '0;
                                pvv_reg   <= {1'b0, var_v_reg};
                                state_reg <= S_OUT;
                            end
                            CMD_PREDICT:
                            begin
                                state_reg <= S_P1;
                            end
                            CMD_BARO:
                            begin
                                zp_reg    <= alt_reg;
                                h0_reg    <= FX_ONE;
                                h1_reg    <= '0;
                                state_reg <= S_U0;
                            end
                            default:
                            begin
                                zp_reg    <= predicted_measurement;
                                h0_reg    <= sens_alt;
                                h1_reg    <= sens_vel;
                                r_reg     <= {1'b0, noise_var};
                                state_reg <= S_U1;
                            end
                        endcase
                    end
                end
                S_OUT:
                begin
                    if (!out_stall)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_U12:
                begin
                    if (div_done)
                    begin
                        tc_reg     <= div_res;
                        issued_reg <= 1'b0;
                        state_reg  <= S_U13;
                    end
                end
                S_U13:
                begin
                    if (div_done)
                    begin
                        td_reg     <= div_res;
                        te_reg     <= z_reg - zp_reg;
                        issued_reg <= 1'b0;
                        state_reg  <= S_U14;
                    end
                end
                default:
                begin
                    // Write back the product and advance
                    if (mul_done)
                    begin
                        issued_reg <= 1'b0;
                        state_reg  <= state_t'(state_reg + 6'd1);
                        case (state_reg)
                            S_P1:  ta_reg <= alt_reg + mul_res;
                            S_P2:  tb_reg <= mul_res;
                            S_P3:  tb_reg <= mul_res;
                            S_P4:  ta_reg <= ta_reg + mul_res;
                            S_P5:  tc_reg <= vel_reg + mul_res;
                            S_P6:  td_reg <= paa_reg + mul_res;
                            S_P7:
                            begin
                                te_reg <= pav_reg + mul_res;
                                tf_reg <= mul_res;
                            end
                            S_P8:  tg_reg <= mul_res;
                            S_P9:  th_reg <= mul_res;
                            S_P10: ti_reg <= mul_res;
                            S_P11: tj_reg <= mul_res;
                            S_P12: ti_reg <= fx_div4(mul_res);
                            S_P13: th_reg <= fx_div2(mul_res);
                            S_P14: tg_reg <= mul_res;
                            S_P15:
                            begin
                                alt_reg   <= ta_reg;
                                vel_reg   <= tc_reg;
                                paa_reg   <= td_reg + mul_res + ti_reg;
                                pav_reg   <= te_reg + th_reg;
                                pva_reg   <= pva_reg + tf_reg + th_reg;
                                pvv_reg   <= pvv_reg + tg_reg;
                                state_reg <= S_OUT;
                            end
                            S_U0:  r_reg  <= mul_res;
                            S_U1:  ta_reg <= mul_res;
                            S_U2:  tb_reg <= mul_res;
                            S_U3:  ta_reg <= mul_res;
                            S_U4:  ta_reg <= mul_res;
                            S_U5:  tb_reg <= tb_reg + mul_res;
                            S_U6:  ta_reg <= mul_res;
                            S_U7:
                            begin
                                // Skip the update when S is not positive
                                tb_reg <= s_val;
                                if (s_bad)
                                begin
                                    status_reg <= 1'b1;
                                    state_reg  <= S_OUT;
                                end
                            end
                            S_U8:  tc_reg <= mul_res;
                            S_U9:  tc_reg <= tc_reg + mul_res;
                            S_U10: td_reg <= mul_res;
                            S_U11: td_reg <= td_reg + mul_res;
                            S_U14: tf_reg <= alt_reg + mul_res;
                            S_U15: tg_reg <= vel_reg + mul_res;
                            S_U16: th_reg <= FX_ONE - mul_res;
                            S_U17: ti_reg <= FX_ONE - mul_res;
                            S_U18: tj_reg <= mul_res;
                            S_U19: ta_reg <= mul_res;
                            S_U20: ta_reg <= ta_reg - mul_res;
                            S_U21: tb_reg <= mul_res;
                            S_U22: tb_reg <= tb_reg - mul_res;
                            S_U23: tj_reg <= mul_res;
                            S_U24: tc_reg <= mul_res;
                            S_U25: tc_reg <= tc_reg + mul_res;
                            S_U26: te_reg <= mul_res;
                            S_U27:
                            begin
                                alt_reg   <= tf_reg;
                                vel_reg   <= tg_reg;
                                paa_reg   <= ta_reg;
                                pav_reg   <= tb_reg;
                                pva_reg   <= tc_reg;
                                pvv_reg   <= te_reg + mul_res;
                                state_reg <= S_OUT;
                            end
                            default: ;
                        endcase
                    end
                end
            endcase
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign altitude  = alt_reg;
    assign velocity  = vel_reg;
    assign cov_aa    = paa_reg;
    assign cov_av    = pav_reg;
    assign cov_va    = pva_reg;
    assign cov_vv    = pvv_reg;
    assign status    = status_reg;

endmodule
